### design/mftp_pkg.sv
`default_nettype none
package mftp_pkg;

   localparam int EW        = 33;
   localparam int CW        = 42;
   localparam int MW        = 41;
   localparam int NW        = 31;
   localparam int PW        = 6;
   localparam int BW        = 18;
   localparam int LW        = 32;
   localparam int NUMW      = 48;
   localparam int CFW       = 38;
   localparam int SQ_STEPS  = 32;
   localparam int DIV_STEPS = 17;
   localparam int UNIT_LAT  = 4 + SQ_STEPS + 1 + DIV_STEPS + 2;
   localparam int ONE_Q     = 65536;

   typedef enum logic [2:0] {
      CSR_INV_REST_00 = 3'd0,
      CSR_INV_REST_01 = 3'd1,
      CSR_INV_REST_10 = 3'd2,
      CSR_INV_REST_11 = 3'd3,
      CSR_FIBER_U     = 3'd4,
      CSR_FIBER_V     = 3'd5,
      CSR_ACTIVATION  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [31:0] r00;
      logic [31:0] r01;
      logic [31:0] r10;
      logic [31:0] r11;
      logic [17:0] fu;
      logic [17:0] fv;
      logic [16:0] act;
   } cfg_type;

   typedef struct packed {
      logic [2:0][EW-1:0] ea;
      logic [2:0][EW-1:0] eb;
   } edges_type;

   typedef struct packed {
      edges_type          e;
      logic [2:0][BW-1:0] bu;
      logic               ok_a;
   } sideb_type;

   typedef struct packed {
      logic [2:0]         neg;
      logic               zero;
      logic [2:0][NW-1:0] nm;
   } carry_type;

   function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] m;
      mag = v[63] ? 64'(-v) : 64'(v);
      m   = (mag + 64'd32768) >> 16;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

### design/mftp_req_if.sv
`default_nettype none
interface mftp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] p0_x;
   logic signed [31:0] p0_y;
   logic signed [31:0] p0_z;
   logic signed [31:0] p1_x;
   logic signed [31:0] p1_y;
   logic signed [31:0] p1_z;
   logic signed [31:0] p2_x;
   logic signed [31:0] p2_y;
   logic signed [31:0] p2_z;

   modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                   input ready);
   modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                 output ready);
endinterface
`default_nettype wire

### design/mftp_rsp_if.sv
`default_nettype none
interface mftp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic signed [31:0] target_z;
   logic               degenerate;

   modport source (output valid, target_x, target_y, target_z, degenerate, input ready);
   modport sink (input valid, target_x, target_y, target_z, degenerate, output ready);
endinterface
`default_nettype wire

### design/mftp_unit.sv
`default_nettype none
module mftp_unit import mftp_pkg::*; #(
   parameter int SideW = 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [2:0][CW-1:0] c_in,
   input  wire logic [SideW-1:0]   side_in,
   output logic                    out_valid,
   output logic [2:0][BW-1:0]      u_out,
   output logic                    ok_out,
   output logic [SideW-1:0]        side_out
);

   localparam int Ul     = UNIT_LAT;
   localparam int TopBit = NW - 1;
   localparam int LastC  = Ul - 2;

   function automatic logic [PW-1:0] msb_pos(input logic [MW-1:0] x);
      logic [PW-1:0] p;
      p = '0;
      for (int i = 0; i < MW; i++) begin
         if (x[i]) p = PW'(i);
      end
      return p;
   endfunction

   logic [Ul-1:0]      v_ff;
   logic [SideW-1:0]   side_ff [Ul];
   logic [MW-1:0]      mg0_ff [3];
   logic [2:0]         neg0_ff;
   logic [MW-1:0]      top0_ff;
   logic [MW-1:0]      top_in;
   logic [PW-1:0]      p1_ff;
   logic               zero1_ff;
   logic [MW-1:0]      mg1_ff [3];
   logic [2:0]         neg1_ff;
   carry_type          cr_ff [2:LastC];
   carry_type          cr_in;
   logic [2*NW-1:0]    sq3_ff [3];
   logic [63:0]        rem_ff [SQ_STEPS+1];
   logic [63:0]        res_ff [SQ_STEPS+1];
   logic [NUMW-1:0]    dn_ff [DIV_STEPS+1][3];
   logic [LW-1:0]      dl_ff [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] dq_ff [DIV_STEPS+1][3];
   logic [2:0][BW-1:0] u_ff;
   logic               ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[Ul-2:0], in_valid};
      end
   end

   always_comb begin
      top_in = '0;
      for (int k = 0; k < 3; k++) begin
         if (c_in[k][CW-1]) begin
            if (MW'(-$signed(c_in[k])) > top_in) top_in = MW'(-$signed(c_in[k]));
         end else begin
            if (MW'(c_in[k]) > top_in) top_in = MW'(c_in[k]);
         end
      end
   end

   always_comb begin
      cr_in.neg  = neg1_ff;
      cr_in.zero = zero1_ff;
      for (int k = 0; k < 3; k++) begin
         if (p1_ff >= PW'(TopBit)) begin
            cr_in.nm[k] = NW'(mg1_ff[k] >> (p1_ff - PW'(TopBit)));
         end else begin
            cr_in.nm[k] = NW'(mg1_ff[k] << (PW'(TopBit) - p1_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < Ul; s++) side_ff[s] <= side_ff[s-1];
         for (int k = 0; k < 3; k++) begin
            mg0_ff[k]  <= c_in[k][CW-1] ? MW'(-$signed(c_in[k])) : MW'(c_in[k]);
            neg0_ff[k] <= c_in[k][CW-1];
            mg1_ff[k]  <= mg0_ff[k];
            sq3_ff[k]  <= cr_ff[2].nm[k] * cr_ff[2].nm[k];
         end
         top0_ff  <= top_in;
         p1_ff    <= msb_pos(top0_ff);
         zero1_ff <= (top0_ff == '0);
         neg1_ff  <= neg0_ff;
         cr_ff[2] <= cr_in;
         for (int s = 3; s <= LastC; s++) cr_ff[s] <= cr_ff[s-1];
         rem_ff[0] <= 64'(sq3_ff[0]) + 64'(sq3_ff[1]) + 64'(sq3_ff[2]);
         res_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      localparam int Sh = 2 * (SQ_STEPS - 1 - i);
      localparam logic [63:0] Bit = 64'(1) << Sh;
      logic [64:0] trial;
      assign trial = {1'b0, res_ff[i]} + {1'b0, Bit};
      always_ff @(posedge clock) begin
         if (en) begin
            if ({1'b0, rem_ff[i]} >= trial) begin
               rem_ff[i+1] <= rem_ff[i] - trial[63:0];
               res_ff[i+1] <= (res_ff[i] >> 1) + Bit;
            end else begin
               rem_ff[i+1] <= rem_ff[i];
               res_ff[i+1] <= res_ff[i] >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_ff[0] <= res_ff[SQ_STEPS][LW-1:0];
         for (int k = 0; k < 3; k++) begin
            dn_ff[0][k] <= (NUMW'(cr_ff[SQ_STEPS+4].nm[k]) << 16)
                           + NUMW'(res_ff[SQ_STEPS][LW-1:1]);
            dq_ff[0][k] <= '0;
         end
      end
   end

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      localparam int B = DIV_STEPS - 1 - i;
      logic [NUMW:0] dv;
      assign dv = (NUMW+1)'(dl_ff[i]) << B;
      always_ff @(posedge clock) begin
         if (en) begin
            dl_ff[i+1] <= dl_ff[i];
            for (int k = 0; k < 3; k++) begin
               if ({1'b0, dn_ff[i][k]} >= dv) begin
                  dn_ff[i+1][k] <= dn_ff[i][k] - dv[NUMW-1:0];
                  dq_ff[i+1][k] <= dq_ff[i][k] | (DIV_STEPS'(1) << B);
               end else begin
                  dn_ff[i+1][k] <= dn_ff[i][k];
                  dq_ff[i+1][k] <= dq_ff[i][k];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok_ff <= !cr_ff[LastC].zero;
         for (int k = 0; k < 3; k++) begin
            if (cr_ff[LastC].zero) begin
               u_ff[k] <= '0;
            end else if (cr_ff[LastC].neg[k]) begin
               u_ff[k] <= BW'(-$signed({1'b0, dq_ff[DIV_STEPS][k]}));
            end else begin
               u_ff[k] <= BW'({1'b0, dq_ff[DIV_STEPS][k]});
            end
         end
      end
   end

   assign out_valid = v_ff[Ul-1];
   assign u_out     = u_ff;
   assign ok_out    = ok_ff;
   assign side_out  = side_ff[Ul-1];

endmodule
`default_nettype wire

### design/mftp_orth.sv
`default_nettype none
module mftp_orth import mftp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire sideb_type          side_in,
   output logic                    out_valid,
   output logic [2:0][CW-1:0]      c_out,
   output sideb_type               side_out
);

   logic [3:0]                 v_ff;
   sideb_type                  sd_ff [4];
   logic signed [EW+BW-1:0]    p0_ff [3];
   logic signed [CFW-1:0]      coef_ff;
   logic signed [CFW+BW-1:0]   p2_ff [3];
   logic [2:0][CW-1:0]         c_ff;
   logic signed [EW+BW+1:0]    acc;

   assign acc = (EW+BW+2)'(p0_ff[0]) + (EW+BW+2)'(p0_ff[1]) + (EW+BW+2)'(p0_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= side_in;
         for (int s = 1; s < 4; s++) sd_ff[s] <= sd_ff[s-1];
         coef_ff <= CFW'(rnd16(64'(acc)));
         for (int k = 0; k < 3; k++) begin
            p0_ff[k] <= $signed(side_in.e.eb[k]) * $signed(side_in.bu[k]);
            p2_ff[k] <= coef_ff * $signed(sd_ff[1].bu[k]);
            c_ff[k]  <= CW'($signed(sd_ff[2].e.eb[k])) - CW'(rnd16(64'(p2_ff[k])));
         end
      end
   end

   assign out_valid = v_ff[3];
   assign c_out     = c_ff;
   assign side_out  = sd_ff[3];

endmodule
`default_nettype wire

### design/mftp_frame.sv
`default_nettype none
module mftp_frame import mftp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire sideb_type          side_in,
   input  wire logic [2:0][BW-1:0] bv_in,
   input  wire logic               ok_b,
   input  wire cfg_type            cfg,
   output logic                    out_valid,
   output logic [2:0][31:0]        target,
   output logic                    degenerate
);

   logic [9:0]                 v_ff;
   logic [2:0][BW-1:0]         bu_ff [6];
   logic [2:0][BW-1:0]         bv_ff [6];
   logic [9:0]                 dg_ff;
   logic signed [EW+BW-1:0]    t0_ff [4][3];
   logic signed [31:0]         a_ff [4];
   logic signed [63:0]         m_ff [8];
   logic signed [31:0]         f_ff [4];
   logic signed [63:0]         n_ff [4];
   logic signed [31:0]         g_ff [2];
   logic signed [63:0]         w_ff [6];
   logic signed [31:0]         h_ff [3];
   logic signed [63:0]         s_ff [3];
   logic [2:0][31:0]           d_ff;
   logic signed [17:0]         scale;

   assign scale = 18'(ONE_Q) - $signed({1'b0, cfg.act});

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[8:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bu_ff[0] <= side_in.bu;
         bv_ff[0] <= bv_in;
         dg_ff    <= {dg_ff[8:0], !(side_in.ok_a && ok_b)};
         for (int s = 1; s < 6; s++) begin
            bu_ff[s] <= bu_ff[s-1];
            bv_ff[s] <= bv_ff[s-1];
         end
         for (int k = 0; k < 3; k++) begin
            t0_ff[0][k] <= $signed(side_in.bu[k]) * $signed(side_in.e.ea[k]);
            t0_ff[1][k] <= $signed(side_in.bu[k]) * $signed(side_in.e.eb[k]);
            t0_ff[2][k] <= $signed(bv_in[k]) * $signed(side_in.e.ea[k]);
            t0_ff[3][k] <= $signed(bv_in[k]) * $signed(side_in.e.eb[k]);
         end
         for (int j = 0; j < 4; j++) begin
            a_ff[j] <= sat32(rnd16(64'(t0_ff[j][0]) + 64'(t0_ff[j][1]) + 64'(t0_ff[j][2])));
         end
         m_ff[0] <= a_ff[0] * $signed(cfg.r00);
         m_ff[1] <= a_ff[1] * $signed(cfg.r10);
         m_ff[2] <= a_ff[0] * $signed(cfg.r01);
         m_ff[3] <= a_ff[1] * $signed(cfg.r11);
         m_ff[4] <= a_ff[2] * $signed(cfg.r00);
         m_ff[5] <= a_ff[3] * $signed(cfg.r10);
         m_ff[6] <= a_ff[2] * $signed(cfg.r01);
         m_ff[7] <= a_ff[3] * $signed(cfg.r11);
         for (int j = 0; j < 4; j++) begin
            f_ff[j] <= sat32(rnd16(m_ff[2*j]) + rnd16(m_ff[2*j+1]));
         end
         n_ff[0] <= f_ff[0] * $signed(cfg.fu);
         n_ff[1] <= f_ff[1] * $signed(cfg.fv);
         n_ff[2] <= f_ff[2] * $signed(cfg.fu);
         n_ff[3] <= f_ff[3] * $signed(cfg.fv);
         g_ff[0] <= sat32(rnd16(n_ff[0]) + rnd16(n_ff[1]));
         g_ff[1] <= sat32(rnd16(n_ff[2]) + rnd16(n_ff[3]));
         for (int k = 0; k < 3; k++) begin
            w_ff[2*k]   <= $signed(bu_ff[5][k]) * g_ff[0];
            w_ff[2*k+1] <= $signed(bv_ff[5][k]) * g_ff[1];
            h_ff[k]     <= sat32(rnd16(w_ff[2*k]) + rnd16(w_ff[2*k+1]));
            s_ff[k]     <= scale * h_ff[k];
            d_ff[k]     <= sat32(rnd16(s_ff[k]));
         end
      end
   end

   assign out_valid  = v_ff[9];
   assign target     = d_ff;
   assign degenerate = dg_ff[9];

endmodule
`default_nettype wire

### design/muscle_fiber_target_projection.sv
// Channel  Dir  Word
// req      in   three vertex positions p0..p2, Q16.16
// rsp      out  target x/y/z Q16.16 saturated, degenerate flag
// csr      in   write enable, index, 32 bit data
//
// One word enters per cycle unless a stall holds it; it passes the entry stage,
// two normaliser pipelines (32 square-root steps and 17 divide steps each), the
// orthogonalisation stages and the frame arithmetic stages. Reset is synchronous,
// clears the valid bits and loads the configuration defaults. A waiting rsp word
// stalls every stage together; req.ready is low exactly while that happens.
`default_nettype none
module muscle_fiber_target_projection import mftp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   mftp_req_if.sink         req,
   mftp_rsp_if.source       rsp,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);

   cfg_type            cfg_ff;
   logic               adv;
   logic               s0_v_ff;
   edges_type          s0_e_ff;
   logic               ua_v;
   logic [2:0][BW-1:0] bu;
   logic               ok_a;
   edges_type          ua_e;
   logic [2:0][CW-1:0] ca;
   logic               or_v;
   logic [2:0][CW-1:0] orth;
   sideb_type          or_sd;
   sideb_type          ub_sd;
   logic               ub_v;
   logic [2:0][BW-1:0] bv;
   logic               ok_b;
   logic [2:0][31:0]   tgt;
   logic               fr_v;
   logic               deg;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.r00 <= 32'(ONE_Q);
         cfg_ff.r01 <= '0;
         cfg_ff.r10 <= '0;
         cfg_ff.r11 <= 32'(ONE_Q);
         cfg_ff.fu  <= 18'(ONE_Q);
         cfg_ff.fv  <= '0;
         cfg_ff.act <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INV_REST_00: cfg_ff.r00 <= csr_wr_data;
            CSR_INV_REST_01: cfg_ff.r01 <= csr_wr_data;
            CSR_INV_REST_10: cfg_ff.r10 <= csr_wr_data;
            CSR_INV_REST_11: cfg_ff.r11 <= csr_wr_data;
            CSR_FIBER_U:     cfg_ff.fu  <= csr_wr_data[17:0];
            CSR_FIBER_V:     cfg_ff.fv  <= csr_wr_data[17:0];
            CSR_ACTIVATION:  cfg_ff.act <= csr_wr_data[16:0];
            default: ;
         endcase
      end
   end

   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_e_ff.ea[0] <= EW'(req.p1_x) - EW'(req.p0_x);
         s0_e_ff.ea[1] <= EW'(req.p1_y) - EW'(req.p0_y);
         s0_e_ff.ea[2] <= EW'(req.p1_z) - EW'(req.p0_z);
         s0_e_ff.eb[0] <= EW'(req.p2_x) - EW'(req.p0_x);
         s0_e_ff.eb[1] <= EW'(req.p2_y) - EW'(req.p0_y);
         s0_e_ff.eb[2] <= EW'(req.p2_z) - EW'(req.p0_z);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) ca[k] = CW'($signed(s0_e_ff.ea[k]));
   end

   mftp_unit #(.SideW($bits(edges_type))) u_unit_a (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s0_v_ff),
      .c_in      (ca),
      .side_in   (s0_e_ff),
      .out_valid (ua_v),
      .u_out     (bu),
      .ok_out    (ok_a),
      .side_out  (ua_e)
   );

   mftp_orth u_orth (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (ua_v),
      .side_in   ('{e: ua_e, bu: bu, ok_a: ok_a}),
      .out_valid (or_v),
      .c_out     (orth),
      .side_out  (or_sd)
   );

   mftp_unit #(.SideW($bits(sideb_type))) u_unit_b (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (or_v),
      .c_in      (orth),
      .side_in   (or_sd),
      .out_valid (ub_v),
      .u_out     (bv),
      .ok_out    (ok_b),
      .side_out  (ub_sd)
   );

   mftp_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (ub_v),
      .side_in    (ub_sd),
      .bv_in      (bv),
      .ok_b       (ok_b),
      .cfg        (cfg_ff),
      .out_valid  (fr_v),
      .target     (tgt),
      .degenerate (deg)
   );

   assign rsp.valid      = fr_v;
   assign rsp.target_x   = tgt[0];
   assign rsp.target_y   = tgt[1];
   assign rsp.target_z   = tgt[2];
   assign rsp.degenerate = deg;

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("req accepted while rsp word waits");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !req.ready |=> ($stable(s0_v_ff) && rsp.valid))
      else $error("pipeline moved during stall");

   a_entry_valid: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> s0_v_ff)
      else $error("accepted word lost at entry stage");

endmodule
`default_nettype wire
